// ===== rtl/core/tsr_pkg.sv =====
// Types, status codes and the fixed repair table for the TSV spare-shift repair block.
`default_nettype none

package tsr_pkg;

    localparam int unsigned MASK_W  = 6;
    localparam int unsigned SHIFT_W = 2;

    // Left spare bit, and the mask that drops it.
    localparam logic [MASK_W-1:0] SPARE_BIT     = 6'h20;
    localparam logic [MASK_W-1:0] NO_SPARE_MASK = 6'h1F;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_UNREPAIRABLE  = 3'd1,
        ST_SPARE_UNAVAIL = 3'd2,
        ST_CHAIN_FAILED  = 3'd3,
        ST_BORROW_AT_END = 3'd4,
        ST_EARLIER_FAIL  = 3'd5
    } t_status;

    typedef struct packed {
        logic               lend;
        logic               borrow;
        logic               fail;
        logic [SHIFT_W-1:0] s3;
        logic [SHIFT_W-1:0] s2;
        logic [SHIFT_W-1:0] s1;
        logic [SHIFT_W-1:0] s0;
    } t_entry;

    typedef struct packed {
        logic [SHIFT_W-1:0] s0;
        logic [SHIFT_W-1:0] s1;
        logic [SHIFT_W-1:0] s2;
        logic [SHIFT_W-1:0] s3;
        logic               borrow;
        t_status            status;
        logic               array_ok;
        logic               last;
    } t_result;

    typedef struct packed {
        logic borrow_pending;
        logic failed_sticky;
    } t_chain;

    localparam t_entry BAD = '{lend: 1'b0, borrow: 1'b0, fail: 1'b1,
                               s3: 2'd0, s2: 2'd0, s1: 2'd0, s0: 2'd0};

    function automatic t_entry mk(input logic [1:0] a, input logic [1:0] b,
                                  input logic [1:0] c, input logic [1:0] d,
                                  input logic m, input logic l);
        t_entry e;
        e.lend   = l;
        e.borrow = m;
        e.fail   = 1'b0;
        e.s0     = a;
        e.s1     = b;
        e.s2     = c;
        e.s3     = d;
        return e;
    endfunction

    function automatic t_entry repair_lookup(input logic [MASK_W-1:0] mask);
        t_entry e;
        case (mask)
            6'd7:    e = mk(2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd11:   e = mk(2'd2, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd13:   e = mk(2'd2, 2'd2, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd14:   e = mk(2'd2, 2'd2, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd15:   e = mk(2'd2, 2'd2, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd19:   e = mk(2'd0, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd21:   e = mk(2'd0, 2'd2, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd22:   e = mk(2'd0, 2'd2, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd23:   e = mk(2'd0, 2'd2, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd25:   e = mk(2'd0, 2'd0, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd26:   e = mk(2'd0, 2'd0, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd27:   e = mk(2'd0, 2'd0, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd28:   e = mk(2'd0, 2'd0, 2'd0, 2'd3, 1'b1, 1'b0);
            6'd29:   e = mk(2'd0, 2'd0, 2'd0, 2'd2, 1'b0, 1'b0);
            6'd30:   e = mk(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
            6'd31:   e = mk(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
            6'd35:   e = mk(2'd1, 2'd3, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd37:   e = mk(2'd1, 2'd2, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd38:   e = mk(2'd1, 2'd2, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd39:   e = mk(2'd1, 2'd2, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd41:   e = mk(2'd1, 2'd0, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd42:   e = mk(2'd1, 2'd0, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd43:   e = mk(2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd44:   e = mk(2'd1, 2'd0, 2'd0, 2'd3, 1'b1, 1'b0);
            6'd45:   e = mk(2'd1, 2'd0, 2'd0, 2'd2, 1'b0, 1'b0);
            6'd46:   e = mk(2'd1, 2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
            6'd47:   e = mk(2'd2, 2'd2, 2'd2, 2'd2, 1'b0, 1'b1);
            6'd49:   e = mk(2'd1, 2'd1, 2'd3, 2'd3, 1'b1, 1'b0);
            6'd50:   e = mk(2'd1, 2'd1, 2'd2, 2'd3, 1'b1, 1'b0);
            6'd51:   e = mk(2'd1, 2'd1, 2'd2, 2'd2, 1'b0, 1'b0);
            6'd52:   e = mk(2'd1, 2'd1, 2'd0, 2'd3, 1'b1, 1'b0);
            6'd53:   e = mk(2'd1, 2'd1, 2'd0, 2'd2, 1'b0, 1'b0);
            6'd54:   e = mk(2'd1, 2'd1, 2'd0, 2'd0, 1'b0, 1'b0);
            6'd55:   e = mk(2'd0, 2'd2, 2'd2, 2'd2, 1'b0, 1'b1);
            6'd56:   e = mk(2'd1, 2'd1, 2'd1, 2'd3, 1'b1, 1'b0);
            6'd57:   e = mk(2'd1, 2'd1, 2'd1, 2'd2, 1'b0, 1'b0);
            6'd58:   e = mk(2'd1, 2'd1, 2'd1, 2'd0, 1'b0, 1'b0);
            6'd59:   e = mk(2'd0, 2'd0, 2'd2, 2'd2, 1'b0, 1'b1);
            6'd60:   e = mk(2'd1, 2'd1, 2'd1, 2'd1, 1'b0, 1'b0);
            6'd61:   e = mk(2'd0, 2'd0, 2'd0, 2'd2, 1'b0, 1'b1);
            6'd62:   e = mk(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b1);
            6'd63:   e = mk(2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b1);
            default: e = BAD;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsv_spare_shift_repair.sv =====
// Top level of the TSV spare-shift repair block: input register, decision, result register.
// A word goes from the input register through the combinational lookup and borrow update
// to the result register. Throughput: one word per cycle unless the output stalls.
// Stalls on the output side back up through the result and input registers.
// Reset clears the valid flags and the borrow and failure chain state.
`default_nettype none

module tsv_spare_shift_repair (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [tsr_pkg::MASK_W-1:0]  i_good_mask,
    input  wire logic                        i_last_block,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [tsr_pkg::SHIFT_W-1:0]      o_pin0_shift,
    output logic [tsr_pkg::SHIFT_W-1:0]      o_pin1_shift,
    output logic [tsr_pkg::SHIFT_W-1:0]      o_pin2_shift,
    output logic [tsr_pkg::SHIFT_W-1:0]      o_pin3_shift,
    output logic                             o_borrow_out,
    output logic [2:0]                       o_block_status,
    output logic                             o_array_ok,
    output logic                             o_last_out
);
    import tsr_pkg::*;

    logic                r_in_valid;
    logic [MASK_W-1:0]   r_mask;
    logic                r_last;
    logic                r_out_valid;
    t_result             r_res;
    t_chain              r_chain;
    t_chain              n_chain;
    t_result             n_res;
    logic                advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    tsr_decide u_decide (
        .i_good_mask  (r_mask),
        .i_last_block (r_last),
        .i_chain      (r_chain),
        .o_result     (n_res),
        .o_chain      (n_chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_chain     <= n_chain;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mask <= i_good_mask;
            r_last <= i_last_block;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pin0_shift   = r_res.s0;
    assign o_pin1_shift   = r_res.s1;
    assign o_pin2_shift   = r_res.s2;
    assign o_pin3_shift   = r_res.s3;
    assign o_borrow_out   = r_res.borrow;
    assign o_block_status = r_res.status;
    assign o_array_ok     = r_res.array_ok;
    assign o_last_out     = r_res.last;

endmodule

`default_nettype wire

// ===== rtl/core/tsr_decide.sv =====
// Per-block repair decision: table lookups, spare lending and chain state update.
`default_nettype none

module tsr_decide (
    input  wire logic [tsr_pkg::MASK_W-1:0] i_good_mask,
    input  wire logic                       i_last_block,
    input  wire tsr_pkg::t_chain            i_chain,
    output tsr_pkg::t_result                o_result,
    output tsr_pkg::t_chain                 o_chain
);
    import tsr_pkg::*;

    t_entry  own_entry;
    t_entry  nospare_entry;
    t_entry  entry;
    t_status status;
    logic    borrow;

    assign own_entry     = repair_lookup(i_good_mask);
    assign nospare_entry = repair_lookup(i_good_mask & NO_SPARE_MASK);

    always_comb begin
        entry  = own_entry;
        status = ST_OK;
        borrow = 1'b0;
        if (i_chain.failed_sticky) begin
            status = ST_EARLIER_FAIL;
        end else if (own_entry.fail) begin
            status = ST_UNREPAIRABLE;
        end else if (i_chain.borrow_pending && !own_entry.lend) begin
            // left spare goes to the block before
            if ((i_good_mask & SPARE_BIT) == '0) begin
                status = ST_SPARE_UNAVAIL;
            end else begin
                entry = nospare_entry;
                if (nospare_entry.fail) begin
                    status = ST_CHAIN_FAILED;
                end
            end
        end
        if (status == ST_OK) begin
            borrow = entry.borrow;
            if (i_last_block && entry.borrow) begin
                status = ST_BORROW_AT_END;
            end
        end
        if (status != ST_OK) begin
            borrow = 1'b0;
        end
    end

    always_comb begin
        o_result.s0       = (status == ST_OK) ? entry.s0 : '0;
        o_result.s1       = (status == ST_OK) ? entry.s1 : '0;
        o_result.s2       = (status == ST_OK) ? entry.s2 : '0;
        o_result.s3       = (status == ST_OK) ? entry.s3 : '0;
        o_result.borrow   = borrow;
        o_result.status   = status;
        o_result.array_ok = i_last_block && (status == ST_OK);
        o_result.last     = i_last_block;
    end

    always_comb begin
        if (i_last_block) begin
            o_chain = '0;
        end else begin
            o_chain.borrow_pending = borrow;
            o_chain.failed_sticky  = i_chain.failed_sticky || (status != ST_OK);
        end
    end

endmodule

`default_nettype wire

// ===== bench/tsv_spare_shift_repair_tb.sv =====
// Self-checking testbench for the TSV spare-shift repair block.
`timescale 1ns / 1ps

module tsv_spare_shift_repair_tb;
    import tsr_pkg::*;

    typedef struct packed {
        logic [3:0][1:0] shift;
        logic            borrow;
        logic [2:0]      status;
        logic            ok;
        logic            last;
    } t_repair_word;

    class repair_scoreboard;
        localparam int FAIL_B   = 8;
        localparam int BORROW_B = 9;
        localparam int LEND_B   = 10;

        // {lend, borrow, fail, s3, s2, s1, s0} per good-via mask
        bit [10:0]    map_tbl [0:63];
        t_repair_word due_words [$];
        bit           borrow_held;
        bit           fail_held;
        int           errors;
        int           arrays_done;
        int           status_seen [0:5];

        function new();
            map_tbl = '{
                11'h100, 11'h100, 11'h100, 11'h100, 11'h100, 11'h100, 11'h100, 11'h2FF,
                11'h100, 11'h100, 11'h100, 11'h2FE, 11'h100, 11'h2FA, 11'h2EA, 11'h0AA,
                11'h100, 11'h100, 11'h100, 11'h2FC, 11'h100, 11'h2F8, 11'h2E8, 11'h0A8,
                11'h100, 11'h2F0, 11'h2E0, 11'h0A0, 11'h2C0, 11'h080, 11'h000, 11'h000,
                11'h100, 11'h100, 11'h100, 11'h2FD, 11'h100, 11'h2F9, 11'h2E9, 11'h0A9,
                11'h100, 11'h2F1, 11'h2E1, 11'h0A1, 11'h2C1, 11'h081, 11'h001, 11'h4AA,
                11'h100, 11'h2F5, 11'h2E5, 11'h0A5, 11'h2C5, 11'h085, 11'h005, 11'h4A8,
                11'h2D5, 11'h095, 11'h015, 11'h4A0, 11'h055, 11'h480, 11'h400, 11'h400
            };
            borrow_held = 1'b0;
            fail_held   = 1'b0;
            errors      = 0;
            arrays_done = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function bit repairable(input logic [5:0] mask);
            return !map_tbl[mask][FAIL_B];
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        function void note_block(input logic [5:0] mask, input logic last);
            t_status      st;
            bit [10:0]    ent;
            bit           brw;
            t_repair_word w;
            st  = ST_OK;
            ent = '0;
            brw = 1'b0;
            if (fail_held) begin
                st = ST_EARLIER_FAIL;
            end else begin
                ent = map_tbl[mask];
                if (ent[FAIL_B]) begin
                    st = ST_UNREPAIRABLE;
                end else if (borrow_held && !ent[LEND_B]) begin
                    if ((mask & SPARE_BIT) == '0) begin
                        st = ST_SPARE_UNAVAIL;
                    end else begin
                        ent = map_tbl[mask & NO_SPARE_MASK];
                        if (ent[FAIL_B])
                            st = ST_CHAIN_FAILED;
                    end
                end
                if (st == ST_OK) begin
                    brw = ent[BORROW_B];
                    if (last && brw)
                        st = ST_BORROW_AT_END;
                end
            end
            if (st != ST_OK) begin
                ent       = '0;
                brw       = 1'b0;
                fail_held = 1'b1;
            end
            borrow_held = brw;
            for (int p = 0; p < 4; p++)
                w.shift[p] = ent[2*p +: 2];
            w.borrow = brw;
            w.status = st;
            w.ok     = last && (st == ST_OK);
            w.last   = last;
            due_words.push_back(w);
            status_seen[st]++;
            if (last) begin
                borrow_held = 1'b0;
                fail_held   = 1'b0;
                arrays_done++;
            end
        endfunction

        function void compare(input string fld, input logic [2:0] want,
                              input logic [2:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
            end
        endfunction

        function void check_word(input t_repair_word got);
            t_repair_word want;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                return;
            end
            want = due_words.pop_front();
            for (int p = 0; p < 4; p++)
                compare($sformatf("pin%0d_shift", p), 3'(want.shift[p]), 3'(got.shift[p]));
            compare("borrow_out", 3'(want.borrow), 3'(got.borrow));
            compare("block_status", want.status, got.status);
            compare("array_ok", 3'(want.ok), 3'(got.ok));
            compare("last_out", 3'(want.last), 3'(got.last));
        endfunction
    endclass

    localparam int RANDOM_BLOCKS = 1950;
    localparam int CYCLE_LIMIT   = 400000;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [5:0] i_good_mask  = '0;
    logic       i_last_block = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_pin0_shift;
    logic [1:0] o_pin1_shift;
    logic [1:0] o_pin2_shift;
    logic [1:0] o_pin3_shift;
    logic       o_borrow_out;
    logic [2:0] o_block_status;
    logic       o_array_ok;
    logic       o_last_out;

    repair_scoreboard sb = new();
    int blocks_sent = 0;
    int send_calm   = 0;
    int recv_calm   = 0;
    int cycle_cnt   = 0;

    tsv_spare_shift_repair dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_good_mask    (i_good_mask),
        .i_last_block   (i_last_block),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pin0_shift   (o_pin0_shift),
        .o_pin1_shift   (o_pin1_shift),
        .o_pin2_shift   (o_pin2_shift),
        .o_pin3_shift   (o_pin3_shift),
        .o_borrow_out   (o_borrow_out),
        .o_block_status (o_block_status),
        .o_array_ok     (o_array_ok),
        .o_last_out     (o_last_out)
    );

    always #2 i_clk = ~i_clk;

    // idle-free stretches now and then
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_block(input logic [5:0] mask, input logic last);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_good_mask  <= mask;
        i_last_block <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_block(mask, last);
        blocks_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // one well-formed array, with some noise and a rare misplaced last marker
    task automatic send_array();
        int         len;
        int         roll;
        logic [5:0] mask;
        logic       last;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int b = 0; b < len; b++) begin
            roll = $urandom_range(0, 99);
            mask = 6'($urandom_range(0, 63));
            if (roll >= 15) begin
                for (int t = 0; t < 8 && !sb.repairable(mask); t++)
                    mask = 6'($urandom_range(0, 63));
                if (sb.borrow_held && roll >= 25)
                    mask = mask | SPARE_BIT;
            end
            last = (b == len - 1);
            if ($urandom_range(0, 39) == 0)
                last = !last;
            send_block(mask, last);
        end
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            int gap;
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_word({o_pin3_shift, o_pin2_shift, o_pin1_shift, o_pin0_shift,
                           o_borrow_out, o_block_status, o_array_ok, o_last_out});
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int goal;
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all good, lends, closes array cleanly
        send_block(6'd63, 1'b1);
        // unrepairable, then earlier failure up to the last block
        send_block(6'd0, 1'b0);
        send_block(6'd15, 1'b0);
        send_block(6'd63, 1'b1);
        // borrow into a lending block
        send_block(6'd7, 1'b0);
        send_block(6'd47, 1'b1);
        // borrow with the left spare dead
        send_block(6'd7, 1'b0);
        send_block(6'd15, 1'b1);
        // borrow ahead of a block that is unrepairable on its own
        send_block(6'd7, 1'b0);
        send_block(6'd32, 1'b1);
        // borrow chain passed on through a spare, then a lender
        send_block(6'd7, 1'b0);
        send_block(6'd39, 1'b0);
        send_block(6'd47, 1'b1);
        // borrow at the end of the array
        send_block(6'd7, 1'b1);
        // plain maps, pin shifts both ways
        send_block(6'd30, 1'b0);
        send_block(6'd60, 1'b0);
        send_block(6'd46, 1'b0);
        send_block(6'd15, 1'b0);
        send_block(6'd31, 1'b1);
        send_block(6'd56, 1'b0);
        send_block(6'd55, 1'b0);
        send_block(6'd63, 1'b1);
        wait_drained();

        goal = blocks_sent + RANDOM_BLOCKS;
        while (blocks_sent < goal) begin
            send_array();
            if (!paused && blocks_sent > goal - RANDOM_BLOCKS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d blocks in %0d arrays, %0d cycles", blocks_sent, sb.arrays_done,
                 cycle_cnt);
        $display("status ok %0d, unrepairable %0d, no spare %0d, chain %0d, end %0d, earlier %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNREPAIRABLE],
                 sb.status_seen[ST_SPARE_UNAVAIL], sb.status_seen[ST_CHAIN_FAILED],
                 sb.status_seen[ST_BORROW_AT_END], sb.status_seen[ST_EARLIER_FAIL]);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
